/* rtl/ied_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ied_pkg
// Shared types and constants for the integer distance pipeline.
// ----------------------------------------------------------------------------
package ied_pkg;

    // radicand bits consumed by one root cell
    localparam int DIGIT_BITS = 2;

    // one radix-4 digit of the radicand
    typedef logic [DIGIT_BITS-1:0] t_digit;

endpackage
`default_nettype wire

/* rtl/ied_prep.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ied_prep
// Three-stage front end: absolute differences, squares, sum of squares.
// ----------------------------------------------------------------------------
module ied_prep #(
    parameter int CW = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [CW-1:0]   i_first_x,
    input  wire logic [CW-1:0]   i_first_y,
    input  wire logic [CW-1:0]   i_second_x,
    input  wire logic [CW-1:0]   i_second_y,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [2*CW:0]        o_sum
);

    logic              r_va, r_vb, r_vc;
    logic [CW-1:0]     r_dx, r_dy;
    logic [2*CW-1:0]   r_sqx, r_sqy;
    logic [2*CW:0]     r_sum;
    logic              adv_a, adv_b, adv_c;
    logic [CW-1:0]     n_dx, n_dy;

    // a stage moves when empty or when the next one moves
    assign adv_c = !r_vc || !i_stall;
    assign adv_b = !r_vb || adv_c;
    assign adv_a = !r_va || adv_b;
    assign o_stall = !adv_a;

    // absolute differences
    always_comb begin
        n_dx = (i_first_x > i_second_x) ? (i_first_x - i_second_x)
                                        : (i_second_x - i_first_x);
        n_dy = (i_first_y > i_second_y) ? (i_first_y - i_second_y)
                                        : (i_second_y - i_first_y);
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (adv_a) r_va <= i_valid;
            if (adv_b) r_vb <= r_va;
            if (adv_c) r_vc <= r_vb;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (adv_b) begin
            r_sqx <= {{CW{1'b0}}, r_dx} * {{CW{1'b0}}, r_dx};
            r_sqy <= {{CW{1'b0}}, r_dy} * {{CW{1'b0}}, r_dy};
        end
        if (adv_c) begin
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
    end

    assign o_valid = r_vc;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

/* rtl/ied_root_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ied_root_cell
// One restoring square-root step: settles one root bit per cell.
// ----------------------------------------------------------------------------
module ied_root_cell #(
    parameter int RW   = 17,
    parameter int STEP = 0
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [ied_pkg::DIGIT_BITS*RW-1:0]      i_rad,
    input  wire logic [RW+1:0]                          i_rem,
    input  wire logic [RW-1:0]                          i_root,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [ied_pkg::DIGIT_BITS*RW-1:0]           o_rad,
    output logic [RW+1:0]                               o_rem,
    output logic [RW-1:0]                               o_root
);
    import ied_pkg::*;

    localparam int RAD_W = DIGIT_BITS * RW;
    localparam int REM_W = RW + 2;
    localparam int DPOS  = RAD_W - 1 - DIGIT_BITS * STEP;

    logic               r_valid;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [RW-1:0]      r_root;
    logic               adv;
    t_digit             digit;
    logic [REM_W-1:0]   rem_sh, trial;
    logic               fits;
    logic [REM_W-1:0]   n_rem;
    logic [RW-1:0]      n_root;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    // trial subtract of (4*root + 1) from the shifted remainder
    always_comb begin
        digit  = i_rad[DPOS -: DIGIT_BITS];
        rem_sh = {i_rem[REM_W-DIGIT_BITS-1:0], digit};
        trial  = {i_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[RW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad  <= i_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule
`default_nettype wire

/* rtl/integer_euclidean_distance.sv */
`default_nettype none
// Pipeline: input word to output word passes three front stages, then one root
//   cell per result bit.
// Throughput: one word per cycle when not stalled; every stage holds its word
//   under stall and empty stages fill while the output waits.
// Reset: synchronous, active low; clears all valid flags, payload is not reset.
// ----------------------------------------------------------------------------
// integer_euclidean_distance
// Floor of the Euclidean distance between two points, via a chain of root cells.
// ----------------------------------------------------------------------------
module integer_euclidean_distance #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [COORD_WIDTH-1:0]  i_first_x,
    input  wire logic [COORD_WIDTH-1:0]  i_first_y,
    input  wire logic [COORD_WIDTH-1:0]  i_second_x,
    input  wire logic [COORD_WIDTH-1:0]  i_second_y,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [COORD_WIDTH:0]         o_distance
);
    import ied_pkg::*;

    localparam int RW    = COORD_WIDTH + 1;
    localparam int RAD_W = DIGIT_BITS * RW;
    localparam int SUM_W = 2 * COORD_WIDTH + 1;

    logic               c_valid [0:RW];
    logic               c_stall [0:RW];
    logic [RAD_W-1:0]   c_rad   [0:RW];
    logic [RW+1:0]      c_rem   [0:RW];
    logic [RW-1:0]      c_root  [0:RW];
    logic [SUM_W-1:0]   sum;

    // front end
    ied_prep #(
        .CW (COORD_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_valid    (c_valid[0]),
        .i_stall    (c_stall[0]),
        .o_sum      (sum)
    );

    // radicand padded to a whole number of digits
    assign c_rad[0]  = {{(RAD_W-SUM_W){1'b0}}, sum};
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    // root cells, most significant result bit first
    for (genvar k = 0; k < RW; k++) begin : g_cell
        ied_root_cell #(
            .RW   (RW),
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_stall (c_stall[k]),
            .i_rad   (c_rad[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .o_valid (c_valid[k+1]),
            .i_stall (c_stall[k+1]),
            .o_rad   (c_rad[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1])
        );
    end

    // last cell doubles as the output register
    assign c_stall[RW] = i_stall;
    assign o_valid     = c_valid[RW];
    assign o_distance  = c_root[RW];

endmodule
`default_nettype wire
